// ===== hw/rtl/vt_escape_sequence_parser_assert.svh =====
// Assertion macros shared by the escape sequence parser modules
`ifndef VT_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`define VT_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
// Antecedent implies consequent in the same cycle
`define VTP_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m: lbl");
// Antecedent implies consequent in the next cycle
`define VTP_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m: lbl");
`endif

// ===== hw/rtl/vtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants of the terminal escape sequence parser.
// ----------------------------------------------------------------------------
package vtp_pkg;
   localparam int MaxParams   = 16;
   localparam int ResultCap   = 16;
   localparam int ParamCap    = (MaxParams < ResultCap) ? MaxParams : ResultCap;
   localparam int PidxW       = (ParamCap > 1) ? $clog2(ParamCap) : 1;
   localparam int PcntW       = $clog2(ParamCap + 1);
   localparam int QDepth      = 2;

   localparam logic [19:0] ParamSat    = 20'd1000000;
   localparam logic [20:0] Replacement = 21'h00FFFD;
   localparam logic [7:0]  PrivBad     = 8'hFF;

   localparam logic [2:0] KIND_PRINT = 3'd0;
   localparam logic [2:0] KIND_CTRL  = 3'd1;
   localparam logic [2:0] KIND_ESC   = 3'd2;
   localparam logic [2:0] KIND_CSI   = 3'd3;
   localparam logic [2:0] KIND_OSC   = 3'd4;
   localparam logic [2:0] KIND_OSCE  = 3'd5;

   // One classified command handed from front to back
   typedef struct packed {
      logic        single;     // emit one result
      logic        burst;      // emit csi parameter run
      logic [2:0]  kind;
      logic [20:0] code_point;
      logic [7:0]  inter;
      logic [7:0]  fin;
      logic [7:0]  priv;
      logic [PcntW-1:0] count;
   } cmd_type;
endpackage

// ===== hw/rtl/vt_escape_sequence_parser.sv =====
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser
// Terminal output byte stream to token converter (UTF-8, ESC, CSI, OSC).
// ----------------------------------------------------------------------------
// Usage: bytes enter on req_valid/req_ready/req_in_byte, one transaction per
// byte. Tokens leave on rsp_valid/rsp_ready with one port per field;
// rsp_last_of_run marks the last token caused by a byte. csr_write_enable
// loads the OSC length limit from csr_write_data; the user must write it
// only while idle, the block does not enforce this. Commands pass through
// the command queue, tokens through the output register. A byte is taken
// once the two-entry command queue is empty; a CSI final waits until
// earlier tokens drain, then its parameter run emits one token per cycle
// (up to 16) while rsp_ready is high from the back end's parameter store.
// Reset: the parser returns to ground state, the queue empties and the
// OSC limit returns to 8192. No clearing pass is needed.
// Stall: when rsp_ready is low the output register holds, the queue backs
// up, and req_ready drops; no token is lost.
// ----------------------------------------------------------------------------
module vt_escape_sequence_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        csr_write_enable,
   input  logic [13:0] csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [20:0] rsp_code_point,
   output logic [7:0]  rsp_intermediate_byte,
   output logic [7:0]  rsp_final_byte,
   output logic [7:0]  rsp_private_marker,
   output logic [19:0] rsp_param_value,
   output logic        rsp_param_is_sub,
   output logic        rsp_last_of_run
);
   logic q_full, q_empty, q_pop, back_busy, cmd_push, pw_en;
   logic [1:0] cmd_cnt;
   vtp_pkg::cmd_type cmd0, cmd1, q_head;
   logic [vtp_pkg::PidxW-1:0] pw_idx;
   logic [20:0] pw_data;
   logic [1:0]  left_ff;

   vtp_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_in_byte,
      .csr_write_enable, .csr_write_data, .q_full, .back_busy,
      .cmd_push, .cmd_cnt, .cmd0, .cmd1, .pw_en, .pw_idx, .pw_data
   );

   vtp_queue u_queue (
      .clock, .reset, .push(cmd_push), .push_cnt(cmd_cnt), .din0(cmd0), .din1(cmd1),
      .full(q_full), .pop(q_pop), .empty(q_empty), .dout(q_head)
   );

   // Track commands left from the current byte to flag its last token
   always_ff @(posedge clock) begin
      if (reset) left_ff <= '0;
      else if (cmd_push) left_ff <= cmd_cnt;
      else if (q_pop) left_ff <= left_ff - 2'd1;
   end

   vtp_back u_back (
      .clock, .reset, .q_empty, .q_head, .q_last(left_ff == 2'd1), .q_pop,
      .busy(back_busy), .pw_en, .pw_idx, .pw_data,
      .rsp_valid, .rsp_ready, .rsp_event_kind, .rsp_code_point,
      .rsp_intermediate_byte, .rsp_final_byte, .rsp_private_marker,
      .rsp_param_value, .rsp_param_is_sub, .rsp_last_of_run
   );
endmodule

// ===== hw/rtl/vtp_front.sv =====
// ----------------------------------------------------------------------------
// vtp_front
// Parser state machine: classifies bytes and queues result commands.
// ----------------------------------------------------------------------------
module vtp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 csr_write_enable,
   input  logic [13:0]          csr_write_data,
   input  logic                 q_full,
   input  logic                 back_busy,
   output logic                 cmd_push,
   output logic [1:0]           cmd_cnt,
   output vtp_pkg::cmd_type     cmd0,
   output vtp_pkg::cmd_type     cmd1,
   output logic                 pw_en,
   output logic [vtp_pkg::PidxW-1:0] pw_idx,
   output logic [20:0]          pw_data
);
   typedef enum logic [2:0] {
      GROUND, ESCAPE, ESC_INTER, CSI, OSC, OSC_ESC, DCS, DCS_ESC
   } mode_type;

   mode_type mode_ff, mode_in;
   logic [1:0]  rem_ff, rem_in;
   logic [20:0] part_ff, part_in;
   logic [7:0]  einter_ff, einter_in;
   logic [19:0] acc_ff, acc_in;
   logic        seen_ff, seen_in, nsub_ff, nsub_in;
   logic [vtp_pkg::PcntW-1:0] pcnt_ff, pcnt_in;
   logic [7:0]  priv_ff, priv_in, cinter_ff, cinter_in;
   logic [13:0] olen_ff, olen_in, omax_ff;

   logic        acc;
   logic [7:0]  b;
   logic [24:0] mul;
   logic [19:0] acc_next;
   vtp_pkg::cmd_type c0, c1;
   logic [1:0]  n;
   logic        push_p;

   // A csi final may not overwrite the store while an earlier run drains
   logic is_final;
   assign b        = req_in_byte;
   assign is_final = (mode_ff == CSI) && b >= 8'h40 && b <= 8'h7E;
   assign req_ready = !q_full && !(is_final && back_busy);
   assign acc      = req_valid && req_ready;

   assign mul      = {5'd0, acc_ff} * 25'd10 + {17'd0, b - 8'h30};
   assign acc_next = (mul > {5'd0, vtp_pkg::ParamSat}) ? vtp_pkg::ParamSat : mul[19:0];

   function automatic vtp_pkg::cmd_type one(input logic [2:0] k, input logic [20:0] cp,
                                            input logic [7:0] it, input logic [7:0] f);
      vtp_pkg::cmd_type c;
      c = '0;
      c.single = 1'b1; c.kind = k; c.code_point = cp; c.inter = it; c.fin = f;
      return c;
   endfunction

   function automatic logic [20:0] fix(input logic [20:0] cp);
      return (cp > 21'h10FFFF || (cp >= 21'h00D800 && cp <= 21'h00DFFF))
             ? vtp_pkg::Replacement : cp;
   endfunction

   always_comb begin
      logic [20:0] pn;
      logic        do_lead, do_esc;
      mode_in = mode_ff; rem_in = rem_ff; part_in = part_ff; einter_in = einter_ff;
      acc_in = acc_ff; seen_in = seen_ff; nsub_in = nsub_ff; pcnt_in = pcnt_ff;
      priv_in = priv_ff; cinter_in = cinter_ff; olen_in = olen_ff;
      c0 = '0; c1 = '0; n = 2'd0; push_p = 1'b0;
      pn = '0; do_lead = 1'b0; do_esc = 1'b0;
      unique case (mode_ff)
         GROUND: begin
            if (b == 8'h1B) begin
               rem_in = 2'd0; mode_in = ESCAPE;
            end else if (b < 8'h20) begin
               rem_in = 2'd0; c0 = one(vtp_pkg::KIND_CTRL, {13'd0, b}, 8'd0, 8'd0); n = 2'd1;
            end else if (b != 8'h7F) begin
               if (rem_ff == 2'd0) begin
                  do_lead = 1'b1;
               end else if (b[7:6] != 2'b10) begin
                  rem_in = 2'd0;
                  c0 = one(vtp_pkg::KIND_PRINT, vtp_pkg::Replacement, 8'd0, 8'd0); n = 2'd1;
                  do_lead = 1'b1;
               end else begin
                  pn = {part_ff[14:0], b[5:0]};
                  part_in = pn; rem_in = rem_ff - 2'd1;
                  if (rem_ff == 2'd1) begin
                     c0 = one(vtp_pkg::KIND_PRINT, fix(pn), 8'd0, 8'd0); n = 2'd1;
                  end
               end
            end
            if (do_lead) begin
               if (!b[7] || b[7:3] == 5'b11111) begin
                  pn = b[7] ? vtp_pkg::Replacement : {13'd0, b};
                  if (n == 2'd0) c0 = one(vtp_pkg::KIND_PRINT, pn, 8'd0, 8'd0);
                  else c1 = one(vtp_pkg::KIND_PRINT, pn, 8'd0, 8'd0);
                  n = n + 2'd1;
               end else if (b[7:5] == 3'b110) begin
                  part_in = {16'd0, b[4:0]}; rem_in = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  part_in = {17'd0, b[3:0]}; rem_in = 2'd2;
               end else if (b[7:3] == 5'b11110) begin
                  part_in = {18'd0, b[2:0]}; rem_in = 2'd3;
               end else begin
                  // stray continuation
                  pn = vtp_pkg::Replacement;
                  if (n == 2'd0) c0 = one(vtp_pkg::KIND_PRINT, pn, 8'd0, 8'd0);
                  else c1 = one(vtp_pkg::KIND_PRINT, pn, 8'd0, 8'd0);
                  n = n + 2'd1;
               end
            end
         end
         ESCAPE: do_esc = 1'b1;
         ESC_INTER: begin
            if (b >= 8'h20 && b <= 8'h2F) begin
               einter_in = b;
            end else begin
               mode_in = GROUND;
               if (b >= 8'h30 && b <= 8'h7E) begin
                  c0 = one(vtp_pkg::KIND_ESC, 21'd0, einter_ff, b); n = 2'd1;
               end
            end
         end
         CSI: begin
            if (b >= 8'h30 && b <= 8'h39) begin
               acc_in = acc_next; seen_in = 1'b1;
            end else if (b == 8'h3B || b == 8'h3A) begin
               push_p = 1'b1; acc_in = '0; seen_in = 1'b0; nsub_in = (b == 8'h3A);
            end else if (b >= 8'h3C && b <= 8'h3F) begin
               priv_in = (pcnt_ff == '0 && !seen_ff) ? b : vtp_pkg::PrivBad;
            end else if (b >= 8'h20 && b <= 8'h2F) begin
               cinter_in = b;
            end else if (b >= 8'h40 && b <= 8'h7E) begin
               push_p = 1'b1; mode_in = GROUND;
               if (priv_ff != vtp_pkg::PrivBad) begin
                  c0 = '0; c0.burst = 1'b1; c0.kind = vtp_pkg::KIND_CSI;
                  c0.inter = cinter_ff; c0.fin = b; c0.priv = priv_ff;
                  c0.count = (pcnt_ff < vtp_pkg::PcntW'(vtp_pkg::ParamCap))
                             ? pcnt_ff + 1'b1 : pcnt_ff;
                  n = 2'd1;
               end
            end else if (b == 8'h1B) begin
               mode_in = ESCAPE;
            end else if (b == 8'h18 || b == 8'h1A) begin
               mode_in = GROUND;
            end else if (b < 8'h20) begin
               c0 = one(vtp_pkg::KIND_CTRL, {13'd0, b}, 8'd0, 8'd0); n = 2'd1;
            end else begin
               mode_in = GROUND;
            end
         end
         OSC: begin
            if (b == 8'h07) begin
               c0 = one(vtp_pkg::KIND_OSCE, 21'd0, 8'd0, 8'd0); n = 2'd1; mode_in = GROUND;
            end else if (b == 8'h1B) begin
               mode_in = OSC_ESC;
            end else if (b == 8'h18 || b == 8'h1A) begin
               mode_in = GROUND;
            end else if (b >= 8'h20 || b == 8'h09) begin
               if (olen_ff < omax_ff) begin
                  c0 = one(vtp_pkg::KIND_OSC, {13'd0, b}, 8'd0, 8'd0); n = 2'd1;
                  olen_in = olen_ff + 14'd1;
               end
            end
         end
         OSC_ESC: begin
            if (b == 8'h5C) begin
               c0 = one(vtp_pkg::KIND_OSCE, 21'd0, 8'd0, 8'd0); n = 2'd1; mode_in = GROUND;
            end else begin
               do_esc = 1'b1;
            end
         end
         DCS: if (b == 8'h1B) mode_in = DCS_ESC;
         DCS_ESC: begin
            if (b == 8'h5C) mode_in = GROUND;
            else if (b != 8'h1B) mode_in = DCS;
         end
         default: mode_in = GROUND;
      endcase
      if (do_esc) begin
         if (b < 8'h20 && b != 8'h1B) begin
            c0 = one(vtp_pkg::KIND_CTRL, {13'd0, b}, 8'd0, 8'd0); n = 2'd1;
            mode_in = ESCAPE;
         end else begin
            mode_in = GROUND;
            case (b)
               8'h5B: begin
                  pcnt_in = '0; acc_in = '0; seen_in = 1'b0; nsub_in = 1'b0;
                  priv_in = '0; cinter_in = '0; mode_in = CSI;
               end
               8'h5D: begin
                  olen_in = '0; mode_in = OSC;
               end
               8'h50, 8'h58, 8'h5E, 8'h5F: mode_in = DCS;
               8'h28, 8'h29, 8'h2A, 8'h2B, 8'h23, 8'h25, 8'h20: begin
                  einter_in = b; mode_in = ESC_INTER;
               end
               8'h1B: mode_in = ESCAPE;
               default: begin
                  if (b >= 8'h30 && b <= 8'h7E) begin
                     c0 = one(vtp_pkg::KIND_ESC, 21'd0, 8'd0, b); n = 2'd1;
                  end
               end
            endcase
         end
      end
      if (push_p) begin
         if (pcnt_ff < vtp_pkg::PcntW'(vtp_pkg::ParamCap)) pcnt_in = pcnt_ff + 1'b1;
      end
   end

   assign cmd_push = acc && (n != 2'd0);
   assign cmd_cnt  = n;
   assign cmd0     = c0;
   assign cmd1     = c1;
   assign pw_en    = acc && push_p && (pcnt_ff < vtp_pkg::PcntW'(vtp_pkg::ParamCap));
   assign pw_idx   = pcnt_ff[vtp_pkg::PidxW-1:0];
   assign pw_data  = {nsub_ff, acc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= GROUND; rem_ff <= '0; part_ff <= '0; einter_ff <= '0;
         acc_ff <= '0; seen_ff <= 1'b0; nsub_ff <= 1'b0; pcnt_ff <= '0;
         priv_ff <= '0; cinter_ff <= '0; olen_ff <= '0; omax_ff <= 14'd8192;
      end else begin
         if (csr_write_enable) omax_ff <= csr_write_data;
         if (acc) begin
            mode_ff <= mode_in; rem_ff <= rem_in; part_ff <= part_in;
            einter_ff <= einter_in; acc_ff <= acc_in; seen_ff <= seen_in;
            nsub_ff <= nsub_in; pcnt_ff <= pcnt_in; priv_ff <= priv_in;
            cinter_ff <= cinter_in; olen_ff <= olen_in;
         end
      end
   end

   `include "vt_escape_sequence_parser_assert.svh"
   `VTP_ASSERT_IMPL(a_cnt_cap, clock, reset, 1'b1, pcnt_ff <= vtp_pkg::PcntW'(vtp_pkg::ParamCap))
   `VTP_ASSERT_IMPL(a_no_push_full, clock, reset, q_full, !cmd_push)
   `VTP_ASSERT_IMPL(a_two_only_print, clock, reset, cmd_push && cmd_cnt == 2'd2,
                    cmd1.kind == vtp_pkg::KIND_PRINT)
endmodule

// ===== hw/rtl/vtp_queue.sv =====
// ----------------------------------------------------------------------------
// vtp_queue
// Short command queue between front and back; takes up to two per cycle.
// ----------------------------------------------------------------------------
module vtp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [1:0]       push_cnt,
   input  vtp_pkg::cmd_type din0,
   input  vtp_pkg::cmd_type din1,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output vtp_pkg::cmd_type dout
);
   vtp_pkg::cmd_type mem_ff [vtp_pkg::QDepth];
   logic [1:0] cnt_ff;
   logic       rd_ff;

   // Accept one byte's commands only when every slot is free
   assign full  = (cnt_ff != 2'd0);
   assign empty = (cnt_ff == 2'd0);
   assign dout  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0;
      end else if (push) begin
         rd_ff  <= 1'b0;
         cnt_ff <= push_cnt;
      end else if (pop) begin
         rd_ff  <= 1'b1;
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[0] <= din0;
         mem_ff[1] <= din1;
      end
   end
endmodule

// ===== hw/rtl/vtp_back.sv =====
// ----------------------------------------------------------------------------
// vtp_back
// Result generator: expands commands into results, owns parameter store.
// ----------------------------------------------------------------------------
module vtp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  vtp_pkg::cmd_type q_head,
   input  logic             q_last,
   output logic             q_pop,
   output logic             busy,
   input  logic             pw_en,
   input  logic [vtp_pkg::PidxW-1:0] pw_idx,
   input  logic [20:0]      pw_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_event_kind,
   output logic [20:0]      rsp_code_point,
   output logic [7:0]       rsp_intermediate_byte,
   output logic [7:0]       rsp_final_byte,
   output logic [7:0]       rsp_private_marker,
   output logic [19:0]      rsp_param_value,
   output logic             rsp_param_is_sub,
   output logic             rsp_last_of_run
);
   logic [20:0] store_ff [vtp_pkg::ParamCap];
   logic [vtp_pkg::PcntW-1:0] idx_ff;
   logic        free, take;
   logic [20:0] ent;
   logic        run_last;

   assign free     = !rsp_valid || rsp_ready;
   assign take     = free && !q_empty;
   assign ent      = store_ff[idx_ff[vtp_pkg::PidxW-1:0]];
   assign run_last = (idx_ff + 1'b1 == q_head.count);
   assign q_pop    = take && (q_head.single || run_last);
   assign busy     = !q_empty || rsp_valid;

   always_ff @(posedge clock) begin
      if (pw_en) store_ff[pw_idx] <= pw_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0; idx_ff <= '0;
      end else begin
         if (free) rsp_valid <= take;
         if (take) begin
            if (q_pop) idx_ff <= '0;
            else idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_event_kind        <= q_head.kind;
         rsp_code_point        <= q_head.code_point;
         rsp_intermediate_byte <= q_head.inter;
         rsp_final_byte        <= q_head.fin;
         rsp_private_marker    <= q_head.priv;
         rsp_param_value       <= q_head.burst ? ent[19:0] : 20'd0;
         rsp_param_is_sub      <= q_head.burst ? ent[20] : 1'b0;
         rsp_last_of_run       <= q_last && (q_head.single || run_last);
      end
   end

   `include "vt_escape_sequence_parser_assert.svh"
   `VTP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `VTP_ASSERT_IMPL(a_burst_idx, clock, reset, !q_empty && q_head.burst,
                    idx_ff < q_head.count)
   `VTP_ASSERT_IMPL(a_pop_nonempty, clock, reset, q_pop, !q_empty)
endmodule
